// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. They sample on clk and are disabled
// while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define NBE_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define NBE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/nbe_pkg.sv =====
// ----------------------------------------------------------------------------
// nbe_pkg
// Shared constants, command and status types, and arithmetic helpers of the
// backward error unit.
// ----------------------------------------------------------------------------
package nbe_pkg;

	localparam int NBE_DATA_W    = 32;
	localparam int NBE_ACC_W     = 64;
	localparam int NBE_CFG_W     = 13;
	localparam int NBE_ETA_W     = 17;
	localparam int NBE_ETA_BITS  = 16;
	localparam int NBE_MAX_ROWS  = 4096;
	localparam int NBE_FRAC_BITS = 16;

	localparam logic [NBE_ETA_W-1:0]  NBE_ETA_ONE = 17'h10000;
	localparam logic [NBE_DATA_W-1:0] NBE_SAT32   = 32'hFFFF_FFFF;

	// Datapath operation selected for one cycle.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_TMP,
		OP_ACC_RE,
		OP_ACC_IM,
		OP_LOAD,
		OP_SQ,
		OP_RAD,
		OP_STORE,
		OP_WSUM,
		OP_DEN,
		OP_ETA,
		OP_REL,
		OP_OUT
	} nbe_op_t;

	// Operand pair of the shared multiplier.
	typedef enum logic [2:0] {
		MUL_ZR_XR,
		MUL_ZI_XI,
		MUL_ZR_XI,
		MUL_ZI_XR,
		MUL_AA,
		MUL_BB,
		MUL_ZX
	} nbe_mul_sel_t;

	// Source and target of a complex magnitude.
	typedef enum logic [1:0] {
		SRC_Z,
		SRC_X,
		SRC_R,
		SRC_B
	} nbe_src_t;

	// Operands of a division.
	typedef enum logic {
		DIV_ETA,
		DIV_REL
	} nbe_div_sel_t;

	typedef struct packed {
		logic         capture;
		nbe_op_t      op;
		nbe_mul_sel_t mul_sel;
		nbe_src_t     src;
		logic         sqrt_start;
		logic         div_start;
		nbe_div_sel_t div_sel;
	} nbe_cmd_t;

	typedef struct packed {
		logic rend;
		logic mend;
		logic sqrt_busy;
		logic div_busy;
	} nbe_status_t;

	// Signed 64-bit add that saturates at the signed limits.
	function automatic logic [NBE_ACC_W-1:0] sat_add64(input logic [NBE_ACC_W-1:0] a,
			input logic [NBE_ACC_W-1:0] b);
		logic [NBE_ACC_W:0] s;
		s = {a[NBE_ACC_W-1], a} + {b[NBE_ACC_W-1], b};
		if (s[NBE_ACC_W] != s[NBE_ACC_W-1]) begin
			sat_add64 = s[NBE_ACC_W] ? {1'b1, {(NBE_ACC_W-1){1'b0}}}
				: {1'b0, {(NBE_ACC_W-1){1'b1}}};
		end else begin
			sat_add64 = s[NBE_ACC_W-1:0];
		end
	endfunction

	// Unsigned 64-bit add that saturates at all ones.
	function automatic logic [NBE_ACC_W-1:0] usat_add64(input logic [NBE_ACC_W-1:0] a,
			input logic [NBE_ACC_W-1:0] b);
		logic [NBE_ACC_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		usat_add64 = s[NBE_ACC_W] ? {NBE_ACC_W{1'b1}} : s[NBE_ACC_W-1:0];
	endfunction

	// Absolute value of a signed 64-bit word: overflow flag over 32 low bits.
	function automatic logic [NBE_DATA_W:0] abs_mag(input logic [NBE_ACC_W-1:0] v);
		logic [NBE_ACC_W-1:0] u;
		u = v[NBE_ACC_W-1] ? (~v + 64'd1) : v;
		abs_mag = {|u[NBE_ACC_W-1:NBE_DATA_W], u[NBE_DATA_W-1:0]};
	endfunction

endpackage

// ===== sv/normwise_backward_error_unit.sv =====
// ----------------------------------------------------------------------------
// normwise_backward_error_unit
// Streaming normwise backward error check of a complex system, one matrix
// element per input transfer, one result transfer per matrix.
// ----------------------------------------------------------------------------
// One element is taken at a time. An element that does not close a row takes
// four signed products, two complex magnitudes, each with a 32-step square
// root, and the weight product. A closing element adds the residual and rhs
// magnitudes and a division for eta; the last element of a matrix adds
// another division for the rhs-relative ratio. One multiplier, one square
// root unit and one divider are shared by all of these steps. The finished
// result waits in an output register, so the next matrix is taken in while
// it is pending.
// ----------------------------------------------------------------------------
module normwise_backward_error_unit #(
	parameter int MAX_ROWS  = nbe_pkg::NBE_MAX_ROWS,
	parameter int FRAC_BITS = nbe_pkg::NBE_FRAC_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [nbe_pkg::NBE_CFG_W-1:0]  cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [nbe_pkg::NBE_DATA_W-1:0] z_re,
	input  logic [nbe_pkg::NBE_DATA_W-1:0] z_im,
	input  logic [nbe_pkg::NBE_DATA_W-1:0] x_re,
	input  logic [nbe_pkg::NBE_DATA_W-1:0] x_im,
	input  logic [nbe_pkg::NBE_DATA_W-1:0] b_re,
	input  logic [nbe_pkg::NBE_DATA_W-1:0] b_im,
	input  logic                           row_end,
	input  logic                           matrix_end,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [nbe_pkg::NBE_DATA_W-1:0] max_residual,
	output logic [nbe_pkg::NBE_DATA_W-1:0] edge_max_residual,
	output logic [nbe_pkg::NBE_DATA_W-1:0] node_max_residual,
	output logic [nbe_pkg::NBE_ETA_W-1:0]  max_eta,
	output logic [nbe_pkg::NBE_ETA_W-1:0]  edge_max_eta,
	output logic [nbe_pkg::NBE_ETA_W-1:0]  node_max_eta,
	output logic [nbe_pkg::NBE_DATA_W-1:0] rhs_relative
);
	import nbe_pkg::*;

	`include "assert_macros.svh"

	nbe_cmd_t    cmd;
	nbe_status_t status;

	// The configuration register is always writable.
	assign cfg_ready = 1'b1;

	nbe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	nbe_datapath #(
		.MAX_ROWS  (MAX_ROWS),
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.cfg_fire          (cfg_valid && cfg_ready),
		.cfg_data          (cfg_data),
		.z_re              (z_re),
		.z_im              (z_im),
		.x_re              (x_re),
		.x_im              (x_im),
		.b_re              (b_re),
		.b_im              (b_im),
		.row_end           (row_end),
		.matrix_end        (matrix_end),
		.max_residual      (max_residual),
		.edge_max_residual (edge_max_residual),
		.node_max_residual (node_max_residual),
		.max_eta           (max_eta),
		.edge_max_eta      (edge_max_eta),
		.node_max_eta      (node_max_eta),
		.rhs_relative      (rhs_relative)
	);

	// A started square root or division must report busy in the next cycle.
	`NBE_ASSERT_NEXT(a_sqrt_runs, cmd.sqrt_start, status.sqrt_busy, "sqrt did not start")
	`NBE_ASSERT_NEXT(a_div_runs, cmd.div_start, status.div_busy, "divider did not start")
	// No new element is taken while an arithmetic unit is still working.
	`NBE_ASSERT_IMPLIES(a_idle_units, in_ready, !status.sqrt_busy && !status.div_busy, "unit busy")
	// Results are never loaded over a pending result.
	`NBE_ASSERT_IMPLIES(a_no_overwrite, cmd.op == OP_OUT, !out_valid, "pending result overwritten")

endmodule

// ===== sv/nbe_isqrt.sv =====
// ----------------------------------------------------------------------------
// nbe_isqrt
// Iterative floor square root of a 64-bit radicand, one result bit a cycle.
// ----------------------------------------------------------------------------
module nbe_isqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [nbe_pkg::NBE_ACC_W-1:0]  radicand,
	output logic                           busy,
	output logic [nbe_pkg::NBE_DATA_W-1:0] root
);
	import nbe_pkg::*;

	localparam logic [NBE_ACC_W-1:0] FIRST_BIT = {2'b01, {(NBE_ACC_W-2){1'b0}}};

	logic                 busy_q;
	logic [NBE_ACC_W-1:0] v_q;
	logic [NBE_ACC_W-1:0] r_q;
	logic [NBE_ACC_W-1:0] bit_q;
	logic [NBE_ACC_W-1:0] trial;
	logic                 take;

	// One step of the digit recurrence.
	assign trial = r_q + bit_q;
	assign take  = (v_q >= trial);

	// Busy runs until the lowest bit has been processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && bit_q[0]) begin
			busy_q <= 1'b0;
		end
	end

	// Remainder, partial root and bit weight.
	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			r_q   <= '0;
			bit_q <= FIRST_BIT;
		end else if (busy_q) begin
			if (take) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = r_q[NBE_DATA_W-1:0];

endmodule

// ===== sv/nbe_divider.sv =====
// ----------------------------------------------------------------------------
// nbe_divider
// Restoring 64-bit by 64-bit unsigned divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module nbe_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [nbe_pkg::NBE_ACC_W-1:0] numer,
	input  logic [nbe_pkg::NBE_ACC_W-1:0] denom,
	output logic                          busy,
	output logic [nbe_pkg::NBE_ACC_W-1:0] quotient
);
	import nbe_pkg::*;

	localparam int CNT_W = $clog2(NBE_ACC_W);

	logic                 busy_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [NBE_ACC_W-1:0] num_q;
	logic [NBE_ACC_W-1:0] den_q;
	logic [NBE_ACC_W-1:0] rem_q;
	logic [NBE_ACC_W-1:0] quo_q;
	logic [NBE_ACC_W:0]   shifted;
	logic [NBE_ACC_W:0]   diff;
	logic                 fits;

	// Shift in the next numerator bit and try a subtraction.
	assign shifted = {rem_q, num_q[NBE_ACC_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = (shifted >= {1'b0, den_q});

	// Bit counter and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == {CNT_W{1'b1}}) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Remainder and quotient registers.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			den_q <= denom;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= fits ? diff[NBE_ACC_W-1:0] : shifted[NBE_ACC_W-1:0];
			quo_q <= {quo_q[NBE_ACC_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// ===== sv/nbe_datapath.sv =====
// ----------------------------------------------------------------------------
// nbe_datapath
// Row accumulators, the shared multiplier, magnitude and ratio arithmetic,
// running maxima and the result registers.
// ----------------------------------------------------------------------------
module nbe_datapath #(
	parameter int MAX_ROWS  = nbe_pkg::NBE_MAX_ROWS,
	parameter int FRAC_BITS = nbe_pkg::NBE_FRAC_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  nbe_pkg::nbe_cmd_t              cmd,
	output nbe_pkg::nbe_status_t           status,
	input  logic                           cfg_fire,
	input  logic [nbe_pkg::NBE_CFG_W-1:0]  cfg_data,
	input  logic [nbe_pkg::NBE_DATA_W-1:0] z_re,
	input  logic [nbe_pkg::NBE_DATA_W-1:0] z_im,
	input  logic [nbe_pkg::NBE_DATA_W-1:0] x_re,
	input  logic [nbe_pkg::NBE_DATA_W-1:0] x_im,
	input  logic [nbe_pkg::NBE_DATA_W-1:0] b_re,
	input  logic [nbe_pkg::NBE_DATA_W-1:0] b_im,
	input  logic                           row_end,
	input  logic                           matrix_end,
	output logic [nbe_pkg::NBE_DATA_W-1:0] max_residual,
	output logic [nbe_pkg::NBE_DATA_W-1:0] edge_max_residual,
	output logic [nbe_pkg::NBE_DATA_W-1:0] node_max_residual,
	output logic [nbe_pkg::NBE_ETA_W-1:0]  max_eta,
	output logic [nbe_pkg::NBE_ETA_W-1:0]  edge_max_eta,
	output logic [nbe_pkg::NBE_ETA_W-1:0]  node_max_eta,
	output logic [nbe_pkg::NBE_DATA_W-1:0] rhs_relative
);
	import nbe_pkg::*;

	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CW    = (RW > NBE_CFG_W) ? RW : NBE_CFG_W;
	localparam int SHR   = (FRAC_BITS >= NBE_ETA_BITS) ? FRAC_BITS - NBE_ETA_BITS : 0;
	localparam int SHL   = (FRAC_BITS >= NBE_ETA_BITS) ? 0 : NBE_ETA_BITS - FRAC_BITS;
	localparam int MUL_W = NBE_DATA_W + 1;
	localparam logic [RW-1:0] LAST_ROW = RW'(MAX_ROWS - 1);

	// Captured item.
	logic [NBE_DATA_W-1:0] zr_q, zi_q, xr_q, xi_q, br_q, bi_q;
	logic                  rend_q, mend_q;

	// Configuration.
	logic [NBE_CFG_W-1:0]  edge_count_q;

	// Multiplier.
	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [2*MUL_W-1:0] mul_p;
	logic [NBE_ACC_W-1:0]      prod_q;
	logic [NBE_ACC_W-1:0]      prod_shr;

	// Row accumulators.
	logic [NBE_ACC_W-1:0] tmp_q;
	logic [NBE_ACC_W-1:0] sum_re_q, sum_im_q, wsum_q;
	logic [RW-1:0]        row_q;

	// Magnitude path.
	logic [NBE_ACC_W-1:0]  src_a, src_b;
	logic [NBE_DATA_W:0]   abs_a, abs_b;
	logic [NBE_DATA_W-1:0] ma_q, mb_q;
	logic                  msat_q;
	logic [NBE_ACC_W-1:0]  sq_q;
	logic [NBE_ACC_W:0]    rad_sum;
	logic [NBE_ACC_W-1:0]  rad_q;
	logic                  radsat_q;
	logic [NBE_DATA_W-1:0] root;
	logic [NBE_DATA_W-1:0] mag;
	logic [NBE_DATA_W-1:0] mz_q, mx_q, rabs_q, babs_q;
	logic                  sqrt_busy;

	// Ratio path.
	logic [NBE_ACC_W-1:0] den_q;
	logic [NBE_ACC_W-1:0] div_num, div_den, div_quo;
	logic                 div_busy;
	logic [NBE_ACC_W-1:0] eta_zero, eta_raw;
	logic [NBE_ETA_W-1:0] eta;
	logic                 is_edge;

	// Running maxima and the ratio of the last matrix.
	logic [NBE_DATA_W-1:0] pk_res_q, pk_edge_res_q, pk_node_res_q, pk_rhs_q, rel_q;
	logic [NBE_ETA_W-1:0]  pk_eta_q, pk_edge_eta_q, pk_node_eta_q;

	// Result registers.
	logic [NBE_DATA_W-1:0] out_res_q, out_edge_res_q, out_node_res_q, out_rel_q;
	logic [NBE_ETA_W-1:0]  out_eta_q, out_edge_eta_q, out_node_eta_q;

	// Item capture on an input transfer.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			zr_q   <= z_re;
			zi_q   <= z_im;
			xr_q   <= x_re;
			xi_q   <= x_im;
			br_q   <= b_re;
			bi_q   <= b_im;
			rend_q <= row_end;
			mend_q <= matrix_end;
		end
	end

	// Edge row boundary register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_count_q <= '0;
		end else if (cfg_fire) begin
			edge_count_q <= cfg_data;
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		case (cmd.mul_sel)
			MUL_ZR_XR: begin
				mul_a = signed'({zr_q[NBE_DATA_W-1], zr_q});
				mul_b = signed'({xr_q[NBE_DATA_W-1], xr_q});
			end
			MUL_ZI_XI: begin
				mul_a = signed'({zi_q[NBE_DATA_W-1], zi_q});
				mul_b = signed'({xi_q[NBE_DATA_W-1], xi_q});
			end
			MUL_ZR_XI: begin
				mul_a = signed'({zr_q[NBE_DATA_W-1], zr_q});
				mul_b = signed'({xi_q[NBE_DATA_W-1], xi_q});
			end
			MUL_ZI_XR: begin
				mul_a = signed'({zi_q[NBE_DATA_W-1], zi_q});
				mul_b = signed'({xr_q[NBE_DATA_W-1], xr_q});
			end
			MUL_AA: begin
				mul_a = signed'({1'b0, ma_q});
				mul_b = signed'({1'b0, ma_q});
			end
			MUL_BB: begin
				mul_a = signed'({1'b0, mb_q});
				mul_b = signed'({1'b0, mb_q});
			end
			MUL_ZX: begin
				mul_a = signed'({1'b0, mz_q});
				mul_b = signed'({1'b0, mx_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk) begin
		prod_q <= mul_p[NBE_ACC_W-1:0];
	end

	// Product scaled back to the input format, rounding toward minus infinity.
	assign prod_shr = {{FRAC_BITS{prod_q[NBE_ACC_W-1]}}, prod_q[NBE_ACC_W-1:FRAC_BITS]};

	// Component pair whose magnitude is formed next.
	always_comb begin
		case (cmd.src)
			SRC_Z: begin
				src_a = {{NBE_DATA_W{zr_q[NBE_DATA_W-1]}}, zr_q};
				src_b = {{NBE_DATA_W{zi_q[NBE_DATA_W-1]}}, zi_q};
			end
			SRC_X: begin
				src_a = {{NBE_DATA_W{xr_q[NBE_DATA_W-1]}}, xr_q};
				src_b = {{NBE_DATA_W{xi_q[NBE_DATA_W-1]}}, xi_q};
			end
			SRC_R: begin
				src_a = sat_add64(sum_re_q, ~{{NBE_DATA_W{br_q[NBE_DATA_W-1]}}, br_q} + 64'd1);
				src_b = sat_add64(sum_im_q, ~{{NBE_DATA_W{bi_q[NBE_DATA_W-1]}}, bi_q} + 64'd1);
			end
			SRC_B: begin
				src_a = {{NBE_DATA_W{br_q[NBE_DATA_W-1]}}, br_q};
				src_b = {{NBE_DATA_W{bi_q[NBE_DATA_W-1]}}, bi_q};
			end
			default: begin
				src_a = '0;
				src_b = '0;
			end
		endcase
	end

	assign abs_a   = abs_mag(src_a);
	assign abs_b   = abs_mag(src_b);
	assign rad_sum = {1'b0, sq_q} + {1'b0, prod_q};
	assign mag     = radsat_q ? NBE_SAT32 : root;

	nbe_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (rad_q),
		.busy     (sqrt_busy),
		.root     (root)
	);

	// Division operands: eta per row, or the rhs-relative ratio at matrix end.
	assign div_num = (cmd.div_sel == DIV_REL)
		? ({{NBE_DATA_W{1'b0}}, pk_res_q} << FRAC_BITS)
		: {{(NBE_ACC_W-NBE_DATA_W-NBE_ETA_BITS){1'b0}}, rabs_q, {NBE_ETA_BITS{1'b0}}};
	assign div_den = (cmd.div_sel == DIV_REL) ? {{NBE_DATA_W{1'b0}}, pk_rhs_q} : den_q;

	nbe_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.numer    (div_num),
		.denom    (div_den),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// Eta of the closed row; a zero denominator rescales the residual itself.
	assign eta_zero = ({{NBE_DATA_W{1'b0}}, rabs_q} >> SHR) << SHL;
	assign eta_raw  = (den_q == '0) ? eta_zero : div_quo;
	assign eta      = (eta_raw > {{(NBE_ACC_W-NBE_ETA_W){1'b0}}, NBE_ETA_ONE})
		? NBE_ETA_ONE : eta_raw[NBE_ETA_W-1:0];
	assign is_edge  = (CW'(row_q) < CW'(edge_count_q));

	// Product, magnitude and ratio working registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_TMP: tmp_q <= prod_shr;
			OP_LOAD: begin
				ma_q   <= abs_a[NBE_DATA_W-1:0];
				mb_q   <= abs_b[NBE_DATA_W-1:0];
				msat_q <= abs_a[NBE_DATA_W] | abs_b[NBE_DATA_W];
			end
			OP_SQ: sq_q <= prod_q;
			OP_RAD: begin
				rad_q    <= rad_sum[NBE_ACC_W-1:0];
				radsat_q <= msat_q | rad_sum[NBE_ACC_W];
			end
			OP_STORE: begin
				case (cmd.src)
					SRC_Z:   mz_q   <= mag;
					SRC_X:   mx_q   <= mag;
					SRC_R:   rabs_q <= mag;
					SRC_B:   babs_q <= mag;
					default: mz_q   <= mag;
				endcase
			end
			OP_DEN: den_q <= usat_add64(wsum_q, {{NBE_DATA_W{1'b0}}, babs_q});
			OP_REL: begin
				if (pk_rhs_q == '0) begin
					rel_q <= pk_res_q;
				end else if (div_quo > {{NBE_DATA_W{1'b0}}, NBE_SAT32}) begin
					rel_q <= NBE_SAT32;
				end else begin
					rel_q <= div_quo[NBE_DATA_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// Row sums, row index and running maxima.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_re_q      <= '0;
			sum_im_q      <= '0;
			wsum_q        <= '0;
			row_q         <= '0;
			pk_res_q      <= '0;
			pk_edge_res_q <= '0;
			pk_node_res_q <= '0;
			pk_rhs_q      <= '0;
			pk_eta_q      <= '0;
			pk_edge_eta_q <= '0;
			pk_node_eta_q <= '0;
		end else begin
			case (cmd.op)
				OP_ACC_RE: sum_re_q <= sat_add64(sum_re_q, tmp_q - prod_shr);
				OP_ACC_IM: sum_im_q <= sat_add64(sum_im_q, tmp_q + prod_shr);
				OP_WSUM: wsum_q <= usat_add64(wsum_q, prod_q >> FRAC_BITS);
				OP_ETA: begin
					if (rabs_q > pk_res_q) pk_res_q <= rabs_q;
					if (babs_q > pk_rhs_q) pk_rhs_q <= babs_q;
					if (eta > pk_eta_q)    pk_eta_q <= eta;
					if (is_edge) begin
						if (rabs_q > pk_edge_res_q) pk_edge_res_q <= rabs_q;
						if (eta > pk_edge_eta_q)    pk_edge_eta_q <= eta;
					end else begin
						if (rabs_q > pk_node_res_q) pk_node_res_q <= rabs_q;
						if (eta > pk_node_eta_q)    pk_node_eta_q <= eta;
					end
					sum_re_q <= '0;
					sum_im_q <= '0;
					wsum_q   <= '0;
					if (row_q < LAST_ROW) begin
						row_q <= row_q + 1'b1;
					end
				end
				OP_OUT: begin
					row_q         <= '0;
					pk_res_q      <= '0;
					pk_edge_res_q <= '0;
					pk_node_res_q <= '0;
					pk_rhs_q      <= '0;
					pk_eta_q      <= '0;
					pk_edge_eta_q <= '0;
					pk_node_eta_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Result registers, loaded once per matrix.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUT) begin
			out_res_q      <= pk_res_q;
			out_edge_res_q <= pk_edge_res_q;
			out_node_res_q <= pk_node_res_q;
			out_eta_q      <= pk_eta_q;
			out_edge_eta_q <= pk_edge_eta_q;
			out_node_eta_q <= pk_node_eta_q;
			out_rel_q      <= rel_q;
		end
	end

	assign status.rend      = rend_q;
	assign status.mend      = mend_q;
	assign status.sqrt_busy = sqrt_busy;
	assign status.div_busy  = div_busy;

	assign max_residual      = out_res_q;
	assign edge_max_residual = out_edge_res_q;
	assign node_max_residual = out_node_res_q;
	assign max_eta           = out_eta_q;
	assign edge_max_eta      = out_edge_eta_q;
	assign node_max_eta      = out_node_eta_q;
	assign rhs_relative      = out_rel_q;

endmodule

// ===== sv/nbe_ctrl.sv =====
// ----------------------------------------------------------------------------
// nbe_ctrl
// Sequencer that steps the datapath through products, magnitudes, the row
// close and the matrix result, and owns the channel handshakes.
// ----------------------------------------------------------------------------
module nbe_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  nbe_pkg::nbe_status_t status,
	output nbe_pkg::nbe_cmd_t    cmd
);
	import nbe_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE,
		S_PRR,
		S_PII,
		S_PRI,
		S_PIR,
		S_PACC,
		S_MLD,
		S_MA,
		S_MB,
		S_MRAD,
		S_MSQ,
		S_MWAIT,
		S_WMUL,
		S_WACC,
		S_DEN,
		S_DIVE,
		S_DWE,
		S_ETA,
		S_DIVR,
		S_DWR,
		S_REL,
		S_OUTW
	} state_t;

	state_t   state_q;
	nbe_src_t src_q;
	logic     out_valid_q;

	// State, magnitude source and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			src_q       <= SRC_Z;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_PRR;
				S_PRR:  state_q <= S_PII;
				S_PII:  state_q <= S_PRI;
				S_PRI:  state_q <= S_PIR;
				S_PIR:  state_q <= S_PACC;
				S_PACC: begin
					src_q   <= SRC_Z;
					state_q <= S_MLD;
				end
				S_MLD:  state_q <= S_MA;
				S_MA:   state_q <= S_MB;
				S_MB:   state_q <= S_MRAD;
				S_MRAD: state_q <= S_MSQ;
				S_MSQ:  state_q <= S_MWAIT;
				S_MWAIT: begin
					if (!status.sqrt_busy) begin
						case (src_q)
							SRC_Z: begin
								src_q   <= SRC_X;
								state_q <= S_MLD;
							end
							SRC_X: state_q <= S_WMUL;
							SRC_R: begin
								src_q   <= SRC_B;
								state_q <= S_MLD;
							end
							SRC_B: state_q <= S_DEN;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_WMUL: state_q <= S_WACC;
				S_WACC: begin
					if (status.rend || status.mend) begin
						src_q   <= SRC_R;
						state_q <= S_MLD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_DEN:  state_q <= S_DIVE;
				S_DIVE: state_q <= S_DWE;
				S_DWE:  if (!status.div_busy) state_q <= S_ETA;
				S_ETA:  state_q <= status.mend ? S_DIVR : S_IDLE;
				S_DIVR: state_q <= S_DWR;
				S_DWR:  if (!status.div_busy) state_q <= S_REL;
				S_REL:  state_q <= S_OUTW;
				S_OUTW: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Command decode.
	always_comb begin
		cmd            = '0;
		cmd.op         = OP_NONE;
		cmd.mul_sel    = MUL_ZR_XR;
		cmd.src        = src_q;
		cmd.div_sel    = DIV_ETA;
		cmd.capture    = (state_q == S_IDLE) && in_valid;
		cmd.sqrt_start = (state_q == S_MSQ);
		cmd.div_start  = (state_q == S_DIVE) || (state_q == S_DIVR);
		case (state_q)
			S_PRR: cmd.mul_sel = MUL_ZR_XR;
			S_PII: begin
				cmd.mul_sel = MUL_ZI_XI;
				cmd.op      = OP_TMP;
			end
			S_PRI: begin
				cmd.mul_sel = MUL_ZR_XI;
				cmd.op      = OP_ACC_RE;
			end
			S_PIR: begin
				cmd.mul_sel = MUL_ZI_XR;
				cmd.op      = OP_TMP;
			end
			S_PACC: cmd.op = OP_ACC_IM;
			S_MLD:  cmd.op = OP_LOAD;
			S_MA:   cmd.mul_sel = MUL_AA;
			S_MB: begin
				cmd.mul_sel = MUL_BB;
				cmd.op      = OP_SQ;
			end
			S_MRAD:  cmd.op = OP_RAD;
			S_MWAIT: cmd.op = status.sqrt_busy ? OP_NONE : OP_STORE;
			S_WMUL:  cmd.mul_sel = MUL_ZX;
			S_WACC:  cmd.op = OP_WSUM;
			S_DEN:   cmd.op = OP_DEN;
			S_ETA:   cmd.op = OP_ETA;
			S_DIVR:  cmd.div_sel = DIV_REL;
			S_REL:   cmd.op = OP_REL;
			S_OUTW:  cmd.op = out_valid_q ? OP_NONE : OP_OUT;
			default: begin
			end
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Backward error unit testbench
// Streams complex matrices into the unit one element per transfer and checks
// every result transfer against a cycle-free behavioral model of the row
// sums, residual magnitudes, backward error ratios and their running maxima.
// ----------------------------------------------------------------------------

// Expected result of one matrix.
typedef struct packed {
	logic [31:0] res;
	logic [31:0] edge_res;
	logic [31:0] node_res;
	logic [16:0] eta;
	logic [16:0] edge_eta;
	logic [16:0] node_eta;
	logic [31:0] rel;
} nbe_summary_t;

class residual_scoreboard;
	localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

	logic [12:0]  edge_rows;
	logic [63:0]  acc_re, acc_im, acc_w;
	int unsigned  row;
	logic [31:0]  pk_res, pk_eres, pk_nres, pk_rhs;
	logic [16:0]  pk_eta, pk_eeta, pk_neta;
	nbe_summary_t pending[$];
	int           errors;

	function new();
		edge_rows = '0;
		errors = 0;
		restart();
	endfunction

	function void restart();
		acc_re = '0; acc_im = '0; acc_w = '0; row = 0;
		pk_res = '0; pk_eres = '0; pk_nres = '0; pk_rhs = '0;
		pk_eta = '0; pk_eeta = '0; pk_neta = '0;
	endfunction

	static function logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
		logic signed [64:0] s;
		s = $signed({a[63], a}) + $signed({b[63], b});
		if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	static function logic [63:0] uadd(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	// Product of two Q values, shifted down with rounding toward minus infinity.
	static function logic [63:0] qmul(logic [31:0] a, logic [31:0] b);
		logic signed [63:0] p;
		p = $signed(a) * $signed(b);
		return p >>> nbe_pkg::NBE_FRAC_BITS;
	endfunction

	static function logic [63:0] root(logic [63:0] v);
		logic [63:0] r, bit_w;
		r = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > v) bit_w >>= 2;
		while (bit_w != 0) begin
			if (v >= r + bit_w) begin
				v -= r + bit_w;
				r = (r >> 1) + bit_w;
			end else begin
				r >>= 1;
			end
			bit_w >>= 2;
		end
		return r;
	endfunction

	// Complex magnitude of two signed 64-bit parts, saturated to 32 bits.
	static function logic [31:0] magnitude(logic [63:0] re, logic [63:0] im);
		logic [63:0] a, b, s, t, m;
		a = re[63] ? -re : re;
		b = im[63] ? -im : im;
		if (a > 64'hFFFF_FFFF || b > 64'hFFFF_FFFF) return '1;
		s = a * a;
		t = b * b;
		if (s > ~t) return '1;
		m = root(s + t);
		return m > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : m[31:0];
	endfunction

	static function logic [63:0] sx(logic [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

	// Note one accepted element.
	function void note_element(logic [31:0] zr, logic [31:0] zi, logic [31:0] xr,
			logic [31:0] xi, logic [31:0] br, logic [31:0] bi, logic rend, logic mend);
		logic [63:0] den, e, rel;
		logic [31:0] rabs, babs;
		logic [16:0] eta;
		nbe_summary_t s;
		acc_re = sadd(acc_re, sadd(qmul(zr, xr), -qmul(zi, xi)));
		acc_im = sadd(acc_im, sadd(qmul(zr, xi), qmul(zi, xr)));
		acc_w = uadd(acc_w, (64'(magnitude(sx(zr), sx(zi))) *
			64'(magnitude(sx(xr), sx(xi)))) >> nbe_pkg::NBE_FRAC_BITS);
		if (rend || mend) begin
			rabs = magnitude(sadd(acc_re, -sx(br)), sadd(acc_im, -sx(bi)));
			babs = magnitude(sx(br), sx(bi));
			den = uadd(acc_w, 64'(babs));
			e = (den != 0) ? (64'(rabs) << 16) / den : 64'(rabs);
			eta = (e > 64'd65536) ? nbe_pkg::NBE_ETA_ONE : e[16:0];
			if (rabs > pk_res) pk_res = rabs;
			if (babs > pk_rhs) pk_rhs = babs;
			if (eta > pk_eta) pk_eta = eta;
			if (row < edge_rows) begin
				if (rabs > pk_eres) pk_eres = rabs;
				if (eta > pk_eeta) pk_eeta = eta;
			end else begin
				if (rabs > pk_nres) pk_nres = rabs;
				if (eta > pk_neta) pk_neta = eta;
			end
			acc_re = '0; acc_im = '0; acc_w = '0;
			if (row < nbe_pkg::NBE_MAX_ROWS - 1) row++;
		end
		if (mend) begin
			if (pk_rhs != 0) begin
				rel = (64'(pk_res) << nbe_pkg::NBE_FRAC_BITS) / pk_rhs;
				if (rel > 64'hFFFF_FFFF) rel = 64'hFFFF_FFFF;
			end else begin
				rel = 64'(pk_res);
			end
			s = '{pk_res, pk_eres, pk_nres, pk_eta, pk_eeta, pk_neta, rel[31:0]};
			pending.push_back(s);
			restart();
		end
	endfunction

	// Compare one result transfer with the oldest expectation.
	function void check_result(nbe_summary_t got);
		nbe_summary_t want;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10) $display("ERROR: unexpected result %h", got);
			return;
		end
		want = pending.pop_front();
		if (got !== want) begin
			errors++;
			if (errors <= 10) begin
				$display("ERROR: result mismatch");
				$display("  max_residual  exp %h got %h", want.res, got.res);
				$display("  edge/node res exp %h %h got %h %h",
					want.edge_res, want.node_res, got.edge_res, got.node_res);
				$display("  max_eta       exp %h got %h", want.eta, got.eta);
				$display("  edge/node eta exp %h %h got %h %h",
					want.edge_eta, want.node_eta, got.edge_eta, got.node_eta);
				$display("  rhs_relative  exp %h got %h", want.rel, got.rel);
			end
		end
	endfunction
endclass

module tb;
	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [12:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] z_re, z_im, x_re, x_im, b_re, b_im;
	logic        row_end, matrix_end;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] max_residual, edge_max_residual, node_max_residual, rhs_relative;
	logic [16:0] max_eta, edge_max_eta, node_max_eta;

	residual_scoreboard sb;
	bit                 feed_done;

	normwise_backward_error_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.z_re(z_re), .z_im(z_im), .x_re(x_re), .x_im(x_im),
		.b_re(b_re), .b_im(b_im), .row_end(row_end), .matrix_end(matrix_end),
		.out_valid(out_valid), .out_ready(out_ready),
		.max_residual(max_residual), .edge_max_residual(edge_max_residual),
		.node_max_residual(node_max_residual), .max_eta(max_eta),
		.edge_max_eta(edge_max_eta), .node_max_eta(node_max_eta),
		.rhs_relative(rhs_relative)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// No gap half of the time, else mostly short gaps and sometimes long ones.
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(1, 4);
		return $urandom_range(20, 300);
	endfunction

	// Random Q15.16 value: full range, small values or extremes.
	function automatic logic [31:0] rnd_q();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '0;
			3, 4: return $urandom;
			default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
		endcase
	endfunction

	task automatic idle(int n);
		repeat (n) @(posedge clk);
	endtask

	// Write the row split register, then let the model follow.
	task automatic write_edge(logic [12:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.edge_rows = v;
	endtask

	task automatic send_element(logic [31:0] zr, zi, xr, xi, br, bi, logic re, me);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			idle(g);
		end
		in_valid <= 1'b1;
		z_re <= zr; z_im <= zi; x_re <= xr; x_im <= xi;
		b_re <= br; b_im <= bi; row_end <= re; matrix_end <= me;
		do @(posedge clk); while (!in_ready);
		sb.note_element(zr, zi, xr, xi, br, bi, re, me);
	endtask

	// One matrix of random content; a row end may be left off the last row.
	task automatic send_matrix(int rows, int cols, ref int count);
		logic [31:0] br, bi;
		for (int r = 0; r < rows; r++) begin
			br = rnd_q();
			bi = rnd_q();
			for (int c = 0; c < cols; c++) begin
				send_element(rnd_q(), rnd_q(), rnd_q(), rnd_q(), br, bi,
					(c == cols - 1) && !((r == rows - 1) && $urandom_range(0, 3) == 0),
					(c == cols - 1) && (r == rows - 1));
				count++;
			end
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		idle(400);
	endtask

	// Result side with random back-pressure.
	initial begin
		int g;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 3) == 0) begin
				g = gap_len();
				if (g > 0) begin
					out_ready <= 1'b0;
					idle(g);
				end
			end
			out_ready <= 1'b1;
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result('{max_residual, edge_max_residual, node_max_residual,
					max_eta, edge_max_eta, node_max_eta, rhs_relative});
		end
	end

	// Stimulus.
	initial begin
		int count;
		logic [12:0] settings [5];
		sb = new();
		settings = '{13'd0, 13'd4096, 13'd1, 13'd3, 13'd8191};
		arst_n = 1'b0;
		cfg_valid = 1'b0; cfg_data = '0; in_valid = 1'b0;
		z_re = '0; z_im = '0; x_re = '0; x_im = '0; b_re = '0; b_im = '0;
		row_end = 1'b0; matrix_end = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		count = 0;

		// Directed: zero system, zero right-hand side, extremes, open last row.
		write_edge(13'd1);
		send_element('0, '0, '0, '0, '0, '0, 1'b0, 1'b1);
		send_element(32'h0001_0000, '0, 32'h0001_0000, '0, '0, '0, 1'b1, 1'b1);
		send_element(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0);
		send_element(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0);
		send_element(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			'0, '0, 1'b0, 1'b0);
		send_element(32'hFFFF_FFFF, 32'h0000_0001, 32'h0002_0000, 32'hFFFE_0000,
			32'h0001_0000, 32'hFFFF_0000, 1'b0, 1'b1);
		send_element(32'h0000_8000, '0, 32'h0000_8000, '0, 32'h0000_4000, '0, 1'b1, 1'b0);
		send_element(32'h0003_0000, 32'h0004_0000, 32'h0001_0000, '0,
			32'h0003_0000, 32'h0004_0000, 1'b1, 1'b1);
		drain();

		// Random matrices over several row splits.
		for (int k = 0; k < 5; k++) begin
			write_edge(settings[k]);
			while (count < (k + 1) * 290)
				send_matrix($urandom_range(1, 5), $urandom_range(1, 4), count);
			drain();
		end
		feed_done = 1'b1;
	end

	// Finish once all stimulus is through.
	initial begin
		wait (feed_done);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#60_000_000;
		$display("Test completed with failures");
		$finish;
	end
endmodule
